@@ hw/rtl/awns_pkg.sv @@
// ----------------------------------------------------------------------------
// awns_pkg
// shared types and constants of the affine warp nearest-neighbour sampler
// ----------------------------------------------------------------------------
package awns_pkg;

	// fixed field widths
	localparam int COORD_W   = 9;
	localparam int PIXEL_W   = 8;
	localparam int COEF_W    = 32;
	localparam int SIZE_W    = 10;
	localparam int CFG_IDX_W = 3;

	// request kinds
	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_MAP  = 1'b1;

	// value returned for a point that falls outside the source
	localparam logic [PIXEL_W-1:0] FILL_SAMPLE = 8'd1;

	// register map
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_INV_M00,
		CFG_INV_M01,
		CFG_INV_M10,
		CFG_INV_M11,
		CFG_SHIFT_X,
		CFG_SHIFT_Y,
		CFG_SRC_WIDTH,
		CFG_SRC_HEIGHT
	} cfg_idx_t;

endpackage

@@ hw/rtl/awns_ram.sv @@
// ----------------------------------------------------------------------------
// awns_ram
// generic single-port ram, one access per cycle while en is high, registered read data
// ----------------------------------------------------------------------------
module awns_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 262144
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end
			rdata <= mem[addr];
		end
	end

endmodule

@@ hw/rtl/affine_warp_nearest_sampler_top.sv @@
// ----------------------------------------------------------------------------
// affine_warp_nearest_sampler_top
// inverse affine warp with nearest-neighbour lookup into an on-chip frame store
// ----------------------------------------------------------------------------
//
//  channel | signals                                    | direction
//  --------+--------------------------------------------+----------
//  in      | in_valid, in_stall, kind, col, row, pixel  | request in
//  out     | out_valid, out_stall, sample, inside_res   | result out
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data  | register write
//
//  one request enters per clock while in_stall is low; a map request passes
//  through the registers s1 to s6 and shows its result from the s6 output
//  register; a load request gives none and writes the store from its s5 register
//  the whole pipeline moves on one enable, held while a result is stalled,
//  so in_stall follows out_valid and out_stall in the same cycle
//  the frame store is a single-port ram: loads and lookups use it in request
//  order at the same stage, so a lookup always sees every earlier load
//  reset clears valid bits and configuration registers only; the store is left as it is
//
// stages
//  s1  request register
//  s2  translated offsets, split into integer and fraction parts
//  s3  eight partial products of the 2x2 matrix
//  s4  mapped point, floor of the exact sum
//  s5  bounds test and store address
//  s6  store read data and output register
// ----------------------------------------------------------------------------
module affine_warp_nearest_sampler_top
	import awns_pkg::*;
#(
	parameter int SRC_MAX_WIDTH   = 512,
	parameter int SRC_MAX_HEIGHT  = 512,
	parameter int COORD_FRAC_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// request channel
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       kind,
	input  logic [COORD_W-1:0]         col,
	input  logic [COORD_W-1:0]         row,
	input  logic [PIXEL_W-1:0]         pixel,
	// result channel
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [PIXEL_W-1:0]         sample,
	output logic                       inside_res,
	// register writes
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [COEF_W-1:0]          cfg_data
);

	localparam int F     = COORD_FRAC_BITS;
	// offset width: integer coordinate shifted up, minus a 32-bit translation
	localparam int DW    = (((F + COORD_W + 1) > COEF_W) ? (F + COORD_W + 1) : COEF_W) + 1;
	localparam int HW    = DW - F;          // integer part of an offset
	localparam int PH    = COEF_W + HW;     // coefficient x integer part
	localparam int PL    = COEF_W + F + 1;  // coefficient x fraction part
	localparam int LW    = PL + 1;          // sum of two fraction products
	localparam int PW    = PH + 2;          // mapped point
	localparam int DEPTH = SRC_MAX_WIDTH * SRC_MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int XW    = $clog2(SRC_MAX_WIDTH);
	localparam int YW    = $clog2(SRC_MAX_HEIGHT);

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	logic signed [COEF_W-1:0] inv_m00_q, inv_m01_q, inv_m10_q, inv_m11_q;
	logic signed [COEF_W-1:0] shift_x_q, shift_y_q;
	logic        [SIZE_W-1:0] src_width_q, src_height_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_m00_q    <= COEF_W'(1) << F;
			inv_m01_q    <= '0;
			inv_m10_q    <= '0;
			inv_m11_q    <= COEF_W'(1) << F;
			shift_x_q    <= '0;
			shift_y_q    <= '0;
			src_width_q  <= SIZE_W'(512);
			src_height_q <= SIZE_W'(512);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_INV_M00:    inv_m00_q    <= cfg_data;
				CFG_INV_M01:    inv_m01_q    <= cfg_data;
				CFG_INV_M10:    inv_m10_q    <= cfg_data;
				CFG_INV_M11:    inv_m11_q    <= cfg_data;
				CFG_SHIFT_X:    shift_x_q    <= cfg_data;
				CFG_SHIFT_Y:    shift_y_q    <= cfg_data;
				CFG_SRC_WIDTH:  src_width_q  <= cfg_data[SIZE_W-1:0];
				CFG_SRC_HEIGHT: src_height_q <= cfg_data[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// pipeline enable: everything advances unless a result is held
	// ------------------------------------------------------------------
	logic adv;

	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	// valid bits
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;

	// ------------------------------------------------------------------
	// s1: request register
	// ------------------------------------------------------------------
	logic               kind_s1;
	logic [COORD_W-1:0] col_s1, row_s1;
	logic [PIXEL_W-1:0] pixel_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s1  <= kind;
			col_s1   <= col;
			row_s1   <= row;
			pixel_s1 <= pixel;
		end
	end

	// ------------------------------------------------------------------
	// s2: offsets from the translation, split at the binary point
	// ------------------------------------------------------------------
	logic signed [DW-1:0] dx, dy;
	logic [AW-1:0]        ld_addr;
	logic                 ld_ok;

	assign dx = $signed(DW'({col_s1, {F{1'b0}}})) - DW'(shift_x_q);
	assign dy = $signed(DW'({row_s1, {F{1'b0}}})) - DW'(shift_y_q);

	// loads beyond the store are dropped
	assign ld_ok   = (32'(col_s1) < 32'(SRC_MAX_WIDTH)) && (32'(row_s1) < 32'(SRC_MAX_HEIGHT));
	assign ld_addr = AW'(row_s1) * AW'(SRC_MAX_WIDTH) + AW'(col_s1);

	logic                 kind_s2, ld_ok_s2;
	logic [AW-1:0]        ld_addr_s2;
	logic [PIXEL_W-1:0]   pixel_s2;
	logic signed [HW-1:0] dxh_s2, dyh_s2;
	logic [F-1:0]         dxl_s2, dyl_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s2    <= kind_s1;
			ld_ok_s2   <= ld_ok;
			ld_addr_s2 <= ld_addr;
			pixel_s2   <= pixel_s1;
			dxh_s2     <= dx[DW-1:F];
			dyh_s2     <= dy[DW-1:F];
			dxl_s2     <= dx[F-1:0];
			dyl_s2     <= dy[F-1:0];
		end
	end

	// ------------------------------------------------------------------
	// s3: partial products, integer and fraction parts kept apart
	// ------------------------------------------------------------------
	logic                 kind_s3, ld_ok_s3;
	logic [AW-1:0]        ld_addr_s3;
	logic [PIXEL_W-1:0]   pixel_s3;
	logic signed [PH-1:0] hx0_s3, hx1_s3, hy0_s3, hy1_s3;
	logic signed [PL-1:0] lx0_s3, lx1_s3, ly0_s3, ly1_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s3    <= kind_s2;
			ld_ok_s3   <= ld_ok_s2;
			ld_addr_s3 <= ld_addr_s2;
			pixel_s3   <= pixel_s2;
			hx0_s3     <= inv_m00_q * dxh_s2;
			hx1_s3     <= inv_m01_q * dyh_s2;
			hy0_s3     <= inv_m10_q * dxh_s2;
			hy1_s3     <= inv_m11_q * dyh_s2;
			lx0_s3     <= inv_m00_q * $signed({1'b0, dxl_s2});
			lx1_s3     <= inv_m01_q * $signed({1'b0, dyl_s2});
			ly0_s3     <= inv_m10_q * $signed({1'b0, dxl_s2});
			ly1_s3     <= inv_m11_q * $signed({1'b0, dyl_s2});
		end
	end

	// ------------------------------------------------------------------
	// s4: mapped point, exact sum floored to whole fraction bits
	// ------------------------------------------------------------------
	logic signed [LW-1:0] lo_x, lo_y, lo_x_sh, lo_y_sh;
	logic signed [PW-1:0] px, py;

	assign lo_x    = LW'(lx0_s3) + LW'(lx1_s3);
	assign lo_y    = LW'(ly0_s3) + LW'(ly1_s3);
	assign lo_x_sh = lo_x >>> F;
	assign lo_y_sh = lo_y >>> F;
	assign px      = PW'(hx0_s3) + PW'(hx1_s3) + PW'(lo_x_sh);
	assign py      = PW'(hy0_s3) + PW'(hy1_s3) + PW'(lo_y_sh);

	logic                 kind_s4, ld_ok_s4;
	logic [AW-1:0]        ld_addr_s4;
	logic [PIXEL_W-1:0]   pixel_s4;
	logic signed [PW-1:0] px_s4, py_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s4    <= kind_s3;
			ld_ok_s4   <= ld_ok_s3;
			ld_addr_s4 <= ld_addr_s3;
			pixel_s4   <= pixel_s3;
			px_s4      <= px;
			py_s4      <= py;
		end
	end

	// ------------------------------------------------------------------
	// s5: strict bounds test against the clamped source size
	// ------------------------------------------------------------------
	logic [PW-1:0] w_ext, h_ext, w_lim, h_lim;
	logic          in_x, in_y;
	logic [XW-1:0] ix;
	logic [YW-1:0] iy;
	logic [AW-1:0] rd_addr;

	assign w_ext = (PW'(src_width_q) < PW'(SRC_MAX_WIDTH))  ? PW'(src_width_q)  : PW'(SRC_MAX_WIDTH);
	assign h_ext = (PW'(src_height_q) < PW'(SRC_MAX_HEIGHT)) ? PW'(src_height_q) : PW'(SRC_MAX_HEIGHT);
	assign w_lim = w_ext << F;
	assign h_lim = h_ext << F;

	assign in_x = (px_s4 > 0) && (px_s4 < $signed(w_lim));
	assign in_y = (py_s4 > 0) && (py_s4 < $signed(h_lim));

	// inside the bounds the truncated position is below the store size
	assign ix      = px_s4[F +: XW];
	assign iy      = py_s4[F +: YW];
	assign rd_addr = AW'(iy) * AW'(SRC_MAX_WIDTH) + AW'(ix);

	logic               kind_s5, we_s5, inside_s5;
	logic [AW-1:0]      addr_s5;
	logic [PIXEL_W-1:0] pixel_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s5   <= kind_s4;
			we_s5     <= valid_s4 && (kind_s4 == KIND_LOAD) && ld_ok_s4;
			inside_s5 <= in_x && in_y;
			addr_s5   <= (kind_s4 == KIND_LOAD) ? ld_addr_s4 : rd_addr;
			pixel_s5  <= pixel_s4;
		end
	end

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			// only lookups produce a result
			valid_s6 <= valid_s5 && (kind_s5 == KIND_MAP);
		end
	end

	// ------------------------------------------------------------------
	// s6: frame store access and output register
	// ------------------------------------------------------------------
	logic [PIXEL_W-1:0] rdata;
	logic               inside_s6;

	awns_ram #(
		.WIDTH (PIXEL_W),
		.DEPTH (DEPTH)
	) u_frame (
		.clk   (clk),
		.en    (adv),
		.we    (we_s5),
		.addr  (addr_s5),
		.wdata (pixel_s5),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			inside_s6 <= inside_s5;
		end
	end

	assign out_valid  = valid_s6;
	assign sample     = inside_s6 ? rdata : FILL_SAMPLE;
	assign inside_res = inside_s6;

	// ------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------
`ifndef SYNTH
	// a lookup leaving stage 5 always shows up as a result
	a_map_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && valid_s5 && (kind_s5 == KIND_MAP)) |=> out_valid)
		else $error("lookup lost between stage 5 and output");

	// a load never shows up as a result
	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && valid_s5 && (kind_s5 == KIND_LOAD)) |=> !out_valid)
		else $error("load produced a result");

	// store writes only come from loads
	a_write_is_load: assert property (@(posedge clk) disable iff (!arst_n)
		we_s5 |-> (valid_s5 && (kind_s5 == KIND_LOAD)))
		else $error("store write without a load");

	// a held pipeline keeps the valid bits of stages 4 and 5
	a_hold_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> ($stable(valid_s4) && $stable(valid_s5)))
		else $error("pipeline moved while held");
`endif

endmodule
